// ----- rtl/awn_pkg.sv -----
// Shared types, register indexes and constants of the affine warp block.
package awn_pkg;

	// Default frame store geometry
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MAX_WIDTH_DEF  = 2048;

	// Field and datapath widths
	localparam int ROW_W      = 10;
	localparam int COL_W      = 11;
	localparam int COEF_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = 44;
	localparam int ACC_W      = 46;
	localparam int COORD_W    = ACC_W - FRAC_W;
	localparam int DIM_W      = 13;
	localparam int FWIDTH_W   = 12;
	localparam int FHEIGHT_W  = 11;
	localparam int PIXEL_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_COEF   = 6;

	// Commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COL_PER_COL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_PER_ROW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PER_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PER_ROW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

	// Coefficient positions inside the coefficient array
	localparam int C_COL_PER_COL = 0;
	localparam int C_COL_PER_ROW = 1;
	localparam int C_COL_OFFSET  = 2;
	localparam int C_ROW_PER_COL = 3;
	localparam int C_ROW_PER_ROW = 4;
	localparam int C_ROW_OFFSET  = 5;

	// Reset values: identity mapping over the full frame
	localparam logic signed [COEF_W-1:0] COEF_ONE     = 32'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_ZERO    = 32'sd0;
	localparam logic [FWIDTH_W-1:0]      FWIDTH_RST   = 12'd2048;
	localparam logic [FHEIGHT_W-1:0]     FHEIGHT_RST  = 11'd1024;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic             command;
		logic [ROW_W-1:0] pixel_row;
		logic [COL_W-1:0] pixel_col;
		logic [7:0]       in_blue;
		logic [7:0]       in_green;
		logic [7:0]       in_red;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       source_outside;
	} out_item_t;

endpackage

// ----- rtl/affine_warp_nearest.sv -----
// Affine image warp with inverse mapping and nearest pixel by truncation.
// A read passes the capture register, the mapping stages and the address register; done rises with the read data.
// Throughput: one item per cycle; busy stays low, the pipeline takes a beat every cycle.
// Writes give no result; done pulses for exactly one cycle and the receiver cannot stall.
// Reset clears the pipeline and loads identity coefficients and the full frame size.
// The frame store has no reset; its contents are undefined until written.
module affine_warp_nearest #(
	parameter int MAX_HEIGHT = awn_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = awn_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  awn_pkg::in_item_t               request,
	output logic                            done,
	output awn_pkg::out_item_t              result,
	input  logic                            cfg_we,
	input  logic [awn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [awn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [awn_pkg::DIM_W-1:0] MAX_W_D = awn_pkg::DIM_W'(MAX_WIDTH);
	localparam logic [awn_pkg::DIM_W-1:0] MAX_H_D = awn_pkg::DIM_W'(MAX_HEIGHT);

	awn_pkg::coef_t                  coef_q [awn_pkg::NUM_COEF];
	logic [awn_pkg::FWIDTH_W-1:0]    frame_width_q;
	logic [awn_pkg::FHEIGHT_W-1:0]   frame_height_q;
	logic [awn_pkg::DIM_W-1:0]       used_w, used_h;

	logic                            vld_s1;
	awn_pkg::in_item_t               item_s1;
	logic                            vld_s4;
	awn_pkg::in_item_t               item_s4;
	logic [awn_pkg::COORD_W-1:0]     src_col_s4, src_row_s4;

	logic                            src_out, wr_in;
	logic [31:0]                     rd_addr_full, wr_addr_full;
	logic                            we_s5, re_s5, outside_s5;
	logic [AW-1:0]                   addr_s5;
	logic [awn_pkg::PIXEL_W-1:0]     wdata_s5;
	logic                            done_s6, outside_s6;
	logic [awn_pkg::PIXEL_W-1:0]     rdata_s6;
	logic [awn_pkg::PIXEL_W-1:0]     mem [DEPTH];

	assign busy = 1'b0;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[awn_pkg::C_COL_PER_COL] <= awn_pkg::COEF_ONE;
			coef_q[awn_pkg::C_COL_PER_ROW] <= awn_pkg::COEF_ZERO;
			coef_q[awn_pkg::C_COL_OFFSET]  <= awn_pkg::COEF_ZERO;
			coef_q[awn_pkg::C_ROW_PER_COL] <= awn_pkg::COEF_ZERO;
			coef_q[awn_pkg::C_ROW_PER_ROW] <= awn_pkg::COEF_ONE;
			coef_q[awn_pkg::C_ROW_OFFSET]  <= awn_pkg::COEF_ZERO;
			frame_width_q  <= awn_pkg::FWIDTH_RST;
			frame_height_q <= awn_pkg::FHEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				awn_pkg::REG_COL_PER_COL, awn_pkg::REG_COL_PER_ROW,
				awn_pkg::REG_COL_OFFSET, awn_pkg::REG_ROW_PER_COL,
				awn_pkg::REG_ROW_PER_ROW, awn_pkg::REG_ROW_OFFSET: begin
					coef_q[cfg_index] <= $signed(cfg_wdata);
				end
				awn_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_wdata[awn_pkg::FWIDTH_W-1:0];
				end
				awn_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_wdata[awn_pkg::FHEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Limit the frame in use to the store size
	assign used_w = (awn_pkg::DIM_W'(frame_width_q) > MAX_W_D)
		? MAX_W_D : awn_pkg::DIM_W'(frame_width_q);
	assign used_h = (awn_pkg::DIM_W'(frame_height_q) > MAX_H_D)
		? MAX_H_D : awn_pkg::DIM_W'(frame_height_q);

	// Capture the accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= request;
	end

	awn_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_item  (item_s1),
		.coef     (coef_q),
		.out_vld  (vld_s4),
		.out_item (item_s4),
		.src_col  (src_col_s4),
		.src_row  (src_row_s4)
	);

	// Check bounds and form the store address
	assign src_out = src_col_s4[awn_pkg::COORD_W-1] | src_row_s4[awn_pkg::COORD_W-1]
		| (src_col_s4 >= awn_pkg::COORD_W'(used_w))
		| (src_row_s4 >= awn_pkg::COORD_W'(used_h));
	assign wr_in = (awn_pkg::DIM_W'(item_s4.pixel_row) < used_h)
		& (awn_pkg::DIM_W'(item_s4.pixel_col) < used_w);
	assign rd_addr_full = 32'(src_row_s4[awn_pkg::DIM_W-1:0]) * 32'(MAX_WIDTH)
		+ 32'(src_col_s4[awn_pkg::DIM_W-1:0]);
	assign wr_addr_full = 32'(item_s4.pixel_row) * 32'(MAX_WIDTH)
		+ 32'(item_s4.pixel_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s5 <= 1'b0;
			re_s5 <= 1'b0;
		end else begin
			we_s5 <= vld_s4 & (item_s4.command == awn_pkg::CMD_WRITE) & wr_in;
			re_s5 <= vld_s4 & (item_s4.command == awn_pkg::CMD_READ);
		end
	end

	always_ff @(posedge clk) begin
		outside_s5 <= src_out;
		addr_s5    <= (item_s4.command == awn_pkg::CMD_WRITE)
			? wr_addr_full[AW-1:0] : rd_addr_full[AW-1:0];
		wdata_s5   <= {item_s4.in_red, item_s4.in_green, item_s4.in_blue};
	end

	// Access the frame store: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (we_s5) begin
			mem[addr_s5] <= wdata_s5;
		end
		rdata_s6 <= mem[addr_s5];
	end

	// Drive the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= re_s5;
		end
	end

	always_ff @(posedge clk) begin
		outside_s6 <= outside_s5;
	end

	assign done                  = done_s6;
	assign result.out_blue       = outside_s6 ? 8'd0 : rdata_s6[7:0];
	assign result.out_green      = outside_s6 ? 8'd0 : rdata_s6[15:8];
	assign result.out_red        = outside_s6 ? 8'd0 : rdata_s6[23:16];
	assign result.source_outside = outside_s6;

endmodule

// ----- rtl/awn_map.sv -----
// Coordinate mapping pipeline: output position to truncated source position.
module awn_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  awn_pkg::in_item_t in_item,
	input  awn_pkg::coef_t    coef [awn_pkg::NUM_COEF],
	output logic              out_vld,
	output awn_pkg::in_item_t out_item,
	output logic [awn_pkg::COORD_W-1:0] src_col,
	output logic [awn_pkg::COORD_W-1:0] src_row
);

	// Divide by 2^16 with truncation toward zero
	function automatic logic [awn_pkg::COORD_W-1:0] trunc_q16(
		input logic signed [awn_pkg::ACC_W-1:0] acc
	);
		logic round_up;
		round_up = acc[awn_pkg::ACC_W-1] & (|acc[awn_pkg::FRAC_W-1:0]);
		return acc[awn_pkg::ACC_W-1:awn_pkg::FRAC_W] + awn_pkg::COORD_W'(round_up);
	endfunction

	logic signed [awn_pkg::PROD_W-1:0] p_cc_s2, p_cr_s2, p_rc_s2, p_rr_s2;
	awn_pkg::coef_t                    off_c_s2, off_r_s2;
	logic signed [awn_pkg::ACC_W-1:0]  acc_c_s3, acc_r_s3;
	logic [awn_pkg::COORD_W-1:0]       col_s4, row_s4;
	awn_pkg::in_item_t                 item_s2, item_s3, item_s4;
	logic                              vld_s2, vld_s3, vld_s4;
	logic signed [awn_pkg::COL_W:0]    col_sx;
	logic signed [awn_pkg::ROW_W:0]    row_sx;

	assign col_sx = $signed({1'b0, in_item.pixel_col});
	assign row_sx = $signed({1'b0, in_item.pixel_row});

	// Advance the valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Multiply, sum, truncate
	always_ff @(posedge clk) begin
		p_cc_s2  <= coef[awn_pkg::C_COL_PER_COL] * col_sx;
		p_cr_s2  <= coef[awn_pkg::C_COL_PER_ROW] * row_sx;
		p_rc_s2  <= coef[awn_pkg::C_ROW_PER_COL] * col_sx;
		p_rr_s2  <= coef[awn_pkg::C_ROW_PER_ROW] * row_sx;
		off_c_s2 <= coef[awn_pkg::C_COL_OFFSET];
		off_r_s2 <= coef[awn_pkg::C_ROW_OFFSET];
		item_s2  <= in_item;

		acc_c_s3 <= awn_pkg::ACC_W'(p_cc_s2) + awn_pkg::ACC_W'(p_cr_s2)
			+ awn_pkg::ACC_W'(off_c_s2);
		acc_r_s3 <= awn_pkg::ACC_W'(p_rc_s2) + awn_pkg::ACC_W'(p_rr_s2)
			+ awn_pkg::ACC_W'(off_r_s2);
		item_s3  <= item_s2;

		col_s4   <= trunc_q16(acc_c_s3);
		row_s4   <= trunc_q16(acc_r_s3);
		item_s4  <= item_s3;
	end

	assign out_vld  = vld_s4;
	assign out_item = item_s4;
	assign src_col  = col_s4;
	assign src_row  = row_s4;

endmodule

// ----- verif/affine_warp_nearest_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the affine warp block: pixel writes, warped reads, register setups.
module affine_warp_nearest_test;
	import awn_pkg::*;

	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 11;
	localparam int PHASE_ITEMS    = 78;
	localparam int MAX_GAP        = 30;
	localparam int WINDOW         = 48;
	localparam int MAX_PRINTS     = 40;

	// Shadow of the warp: register copy, frame store copy and pending pixels
	class warp_scoreboard;
		coef_t                 coef [NUM_COEF];
		logic [FWIDTH_W-1:0]   width_reg;
		logic [FHEIGHT_W-1:0]  height_reg;
		logic [PIXEL_W-1:0]    pixels [int];
		out_item_t             expected_q [$];
		int                    errors;

		function new();
			coef[C_COL_PER_COL] = COEF_ONE;
			coef[C_COL_PER_ROW] = COEF_ZERO;
			coef[C_COL_OFFSET]  = COEF_ZERO;
			coef[C_ROW_PER_COL] = COEF_ZERO;
			coef[C_ROW_PER_ROW] = COEF_ONE;
			coef[C_ROW_OFFSET]  = COEF_ZERO;
			width_reg  = FWIDTH_RST;
			height_reg = FHEIGHT_RST;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH:  width_reg = data[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_reg = data[FHEIGHT_W-1:0];
				default:          coef[idx] = data;
			endcase
		endfunction

		// Clamp the frame in use to the store
		function int frame_cols();
			return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
		endfunction

		function int frame_rows();
			return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg);
		endfunction

		function int pixel_key(input longint r, input longint c);
			return int'(r * MAX_WIDTH_DEF + c);
		endfunction

		// Inverse map in Q15.16, truncated toward zero
		function void map_source(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
				output longint src_row, output longint src_col);
			longint r;
			longint c;
			r = longint'(row);
			c = longint'(col);
			src_col = (longint'(coef[C_COL_PER_COL]) * c + longint'(coef[C_COL_PER_ROW]) * r
				+ longint'(coef[C_COL_OFFSET])) / longint'(1 << FRAC_W);
			src_row = (longint'(coef[C_ROW_PER_COL]) * c + longint'(coef[C_ROW_PER_ROW]) * r
				+ longint'(coef[C_ROW_OFFSET])) / longint'(1 << FRAC_W);
		endfunction

		function bit source_inside(input longint sr, input longint sc);
			return sc >= 0 && sc < frame_cols() && sr >= 0 && sr < frame_rows();
		endfunction

		// A read that would land on a store entry nobody wrote yet
		function bit source_missing(input in_item_t it, output logic [ROW_W-1:0] src_row,
				output logic [COL_W-1:0] src_col);
			longint sr;
			longint sc;
			map_source(it.pixel_row, it.pixel_col, sr, sc);
			src_row = sr[ROW_W-1:0];
			src_col = sc[COL_W-1:0];
			return it.command == CMD_READ && source_inside(sr, sc)
				&& !pixels.exists(pixel_key(sr, sc));
		endfunction

		function void note_request(input in_item_t it);
			longint sr;
			longint sc;
			out_item_t want;
			logic [PIXEL_W-1:0] px;
			if (it.command == CMD_WRITE) begin
				// drop writes beyond the frame in use
				if (it.pixel_row < frame_rows() && it.pixel_col < frame_cols())
					pixels[pixel_key(it.pixel_row, it.pixel_col)] =
						{it.in_red, it.in_green, it.in_blue};
				return;
			end
			map_source(it.pixel_row, it.pixel_col, sr, sc);
			if (!source_inside(sr, sc)) begin
				want.out_blue       = '0;
				want.out_green      = '0;
				want.out_red        = '0;
				want.source_outside = 1'b1;
			end else begin
				px = pixels.exists(pixel_key(sr, sc)) ? pixels[pixel_key(sr, sc)] : '0;
				want.out_blue       = px[7:0];
				want.out_green      = px[15:8];
				want.out_red        = px[23:16];
				want.source_outside = 1'b0;
			end
			expected_q.push_back(want);
		endfunction

		task report_mismatch(input string what);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_pixel(input out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("pixel %h with no read pending", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.out_blue !== want.out_blue)
				report_mismatch($sformatf("blue %h, want %h", got.out_blue, want.out_blue));
			if (got.out_green !== want.out_green)
				report_mismatch($sformatf("green %h, want %h", got.out_green, want.out_green));
			if (got.out_red !== want.out_red)
				report_mismatch($sformatf("red %h, want %h", got.out_red, want.out_red));
			if (got.source_outside !== want.source_outside)
				report_mismatch($sformatf("outside flag %b, want %b",
					got.source_outside, want.source_outside));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_item_t              request;
	logic                  done;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	warp_scoreboard sb = new();
	int quiet_cycles = 0;

	affine_warp_nearest dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Observe every beat at the edge that accepts it; end a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_register(cfg_index, cfg_wdata);
			if (start && !busy)
				sb.note_request(request);
			if (done)
				sb.check_pixel(result);
			if (cfg_we || (start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Hold start and the request until a beat goes in; start stays high afterward
	task automatic send_request(input in_item_t it);
		start   <= 1'b1;
		request <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_pixel(input logic cmd, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [7:0] blue, input logic [7:0] green,
			input logic [7:0] red);
		in_item_t it;
		it.command   = cmd;
		it.pixel_row = row;
		it.pixel_col = col;
		it.in_blue   = blue;
		it.in_green  = green;
		it.in_red    = red;
		send_request(it);
	endtask

	// Idle the sender for a random gap, pct percent chance per cycle
	task automatic pause_sender(input int pct);
		int n;
		n = 0;
		while (n < MAX_GAP && $urandom_range(99) < pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending until every pending pixel is back, then idle tail cycles
	task automatic drain(input int tail);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Load all registers on an idle block; frame size words carry junk upper bits
	task automatic reconfigure(input coef_t c_cc, input coef_t c_cr, input coef_t c_co,
			input coef_t c_rc, input coef_t c_rr, input coef_t c_ro, input int cols,
			input int rows);
		logic [CFG_DATA_W-1:0] data [8];
		data[REG_COL_PER_COL]  = c_cc;
		data[REG_COL_PER_ROW]  = c_cr;
		data[REG_COL_OFFSET]   = c_co;
		data[REG_ROW_PER_COL]  = c_rc;
		data[REG_ROW_PER_ROW]  = c_rr;
		data[REG_ROW_OFFSET]   = c_ro;
		data[REG_FRAME_WIDTH]  = ($urandom() & ~((1 << FWIDTH_W) - 1)) | cols;
		data[REG_FRAME_HEIGHT] = ($urandom() & ~((1 << FHEIGHT_W) - 1)) | rows;
		drain(DRAIN_CYCLES);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_wdata <= data[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly positions near the origin so that frames overlap; the rest full range
	function automatic in_item_t random_item();
		in_item_t it;
		it.command = ($urandom_range(99) < 55) ? CMD_READ : CMD_WRITE;
		if ($urandom_range(99) < 75) begin
			it.pixel_row = $urandom_range(WINDOW - 1);
			it.pixel_col = $urandom_range(WINDOW - 1);
		end else begin
			it.pixel_row = $urandom_range((1 << ROW_W) - 1);
			it.pixel_col = $urandom_range((1 << COL_W) - 1);
		end
		it.in_blue  = $urandom_range(255);
		it.in_green = $urandom_range(255);
		it.in_red   = $urandom_range(255);
		return it;
	endfunction

	// Write the source pixel first when a read would hit an unwritten entry
	task automatic issue_random(input int pct);
		in_item_t it;
		in_item_t fill;
		logic [ROW_W-1:0] sr;
		logic [COL_W-1:0] sc;
		it = random_item();
		if (sb.source_missing(it, sr, sc)) begin
			fill           = random_item();
			fill.command   = CMD_WRITE;
			fill.pixel_row = sr;
			fill.pixel_col = sc;
			pause_sender(pct);
			send_request(fill);
		end
		pause_sender(pct);
		send_request(it);
	endtask

	initial begin
		int idle_pct;
		bit burst;
		coef_t k [NUM_COEF];
		int cols;
		int rows;

		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// corners of the full frame under the reset identity map
		send_pixel(CMD_WRITE, 10'd0, 11'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_WRITE, 10'd1023, 11'd2047, 8'hff, 8'hff, 8'hff);
		send_pixel(CMD_WRITE, 10'd0, 11'd2047, 8'ha5, 8'h5a, 8'hc3);
		send_pixel(CMD_WRITE, 10'd1023, 11'd0, 8'h3c, 8'h96, 8'h69);
		send_pixel(CMD_WRITE, 10'd1, 11'd1, 8'h12, 8'h34, 8'h56);
		send_pixel(CMD_READ, 10'd0, 11'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd1023, 11'd2047, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd0, 11'd2047, 8'hff, 8'hff, 8'hff);
		send_pixel(CMD_READ, 10'd1023, 11'd0, 8'hff, 8'hff, 8'hff);

		// one-pixel frame, offsets of minus one half: sources in (-1, 0) count as inside
		reconfigure(COEF_ONE, COEF_ZERO, -32'sd32768, COEF_ZERO, COEF_ONE, -32'sd32768, 1, 1);
		send_pixel(CMD_READ, 10'd0, 11'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd1, 11'd1, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd1023, 11'd2047, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_WRITE, 10'd1, 11'd1, 8'hee, 8'hee, 8'hee);
		send_pixel(CMD_WRITE, 10'd0, 11'd1, 8'hee, 8'hee, 8'hee);

		// oversized frame clamps to the store; the dropped write left the old pixel
		reconfigure(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO, 4095, 2047);
		send_pixel(CMD_READ, 10'd1, 11'd1, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd1023, 11'd2047, 8'h00, 8'h00, 8'h00);
		send_pixel(CMD_READ, 10'd0, 11'd2047, 8'h00, 8'h00, 8'h00);

		// empty frame: writes drop, reads report outside
		reconfigure(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO, 0, 0);
		send_pixel(CMD_WRITE, 10'd0, 11'd0, 8'h77, 8'h77, 8'h77);
		send_pixel(CMD_READ, 10'd0, 11'd0, 8'h00, 8'h00, 8'h00);
		reconfigure(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO, 2048, 1024);
		send_pixel(CMD_READ, 10'd0, 11'd0, 8'h00, 8'h00, 8'h00);

		// random traffic under a series of register setups
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: reconfigure(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
					32, 24);
				1: reconfigure(COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ZERO,
					2048, 1024);
				2: reconfigure(32'sd32768, COEF_ZERO, -32'sd32767, COEF_ZERO, 32'sd32768,
					-32'sd32767, 37, 29);
				3: reconfigure(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
					0, 7);
				4: reconfigure(-32'sd65536, COEF_ZERO, 32'sh07FF0000, COEF_ZERO, -32'sd65536,
					32'sh03FF0000, 4095, 2047);
				5: reconfigure(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
					32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 1);
				default: begin
					// near-identity with shear, fractional scale and offsets
					k[C_COL_PER_COL] = 32'd65536 + $urandom_range(65536) - 32'd32768;
					k[C_COL_PER_ROW] = $urandom_range(32768) - 32'd16384;
					k[C_COL_OFFSET]  = $urandom_range(1 << 20) - (32'd1 << 19);
					k[C_ROW_PER_COL] = $urandom_range(32768) - 32'd16384;
					k[C_ROW_PER_ROW] = 32'd65536 + $urandom_range(65536) - 32'd32768;
					k[C_ROW_OFFSET]  = $urandom_range(1 << 20) - (32'd1 << 19);
					if (ph == PHASES - 1) begin
						cols = $urandom_range((1 << FWIDTH_W) - 1);
						rows = $urandom_range((1 << FHEIGHT_W) - 1);
					end else begin
						cols = $urandom_range(40, 1);
						rows = $urandom_range(40, 1);
					end
					reconfigure(k[C_COL_PER_COL], k[C_COL_PER_ROW], k[C_COL_OFFSET],
						k[C_ROW_PER_COL], k[C_ROW_PER_ROW], k[C_ROW_OFFSET], cols, rows);
				end
			endcase
			idle_pct = (ph % 3 == 1) ? 81 : (ph % 3 == 2) ? 31 : 0;
			burst = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 16 == 0)
					burst = ($urandom_range(3) == 0);
				if (n == PHASE_ITEMS / 2)
					drain(0);
				issue_random(burst ? 0 : idle_pct);
			end
		end

		drain(DRAIN_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- affine_warp_nearest.f -----
rtl/awn_pkg.sv
rtl/awn_map.sv
rtl/affine_warp_nearest.sv
verif/affine_warp_nearest_test.sv
